/* src/x86enc_pkg.sv */
package x86enc_pkg;

	typedef logic [7:0] byte_t;

	// Operation codes of a request
	localparam logic [4:0] OP_RET     = 5'd0;
	localparam logic [4:0] OP_LDI     = 5'd1;
	localparam logic [4:0] OP_LOAD    = 5'd2;
	localparam logic [4:0] OP_STORE   = 5'd3;
	localparam logic [4:0] OP_ADD     = 5'd4;
	localparam logic [4:0] OP_XOR     = 5'd8;
	localparam logic [4:0] OP_MUL     = 5'd9;
	localparam logic [4:0] OP_ADD_IMM = 5'd10;
	localparam logic [4:0] OP_XOR_IMM = 5'd14;
	localparam logic [4:0] OP_NEG     = 5'd15;
	localparam logic [4:0] OP_NOT     = 5'd16;
	localparam logic [4:0] OP_MOVE    = 5'd17;

	localparam int MaxBytes = 7;

	// Encoded instruction handed to the byte serializer
	typedef struct packed {
		logic [MaxBytes-1:0][7:0] bytes;
		logic [2:0]               last_idx;
	} code_t;

endpackage

/* src/x86enc_if.sv */
interface x86enc_req_if;
	logic               valid;
	logic               ready;
	logic [4:0]         opcode;
	logic [2:0]         reg_a;
	logic [2:0]         reg_b;
	logic [2:0]         reg_out;
	logic signed [31:0] immediate;

	modport source (output valid, opcode, reg_a, reg_b, reg_out, immediate, input ready);
	modport sink (input valid, opcode, reg_a, reg_b, reg_out, immediate, output ready);
endinterface

interface x86enc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;
	logic       last_byte;

	modport source (output valid, code_byte, last_byte, input ready);
	modport sink (input valid, code_byte, last_byte, output ready);
endinterface

/* src/x86enc_ser.sv */
module x86enc_ser
	import x86enc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  code_t                in_code,
	x86enc_byte_if.source        code
);

	logic                      busy_q;
	logic [2:0]                idx_q;
	logic [2:0]                last_q;
	logic [MaxBytes-1:0][7:0]  bytes_q;
	logic                      at_last;
	logic                      load;

	assign at_last  = (idx_q == last_q);
	// Take the next instruction while the final byte of this one leaves
	assign in_ready = !busy_q || (code.ready && at_last);
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q && code.ready) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= in_code.bytes;
			last_q  <= in_code.last_idx;
		end
	end

	assign code.valid     = busy_q;
	assign code.code_byte = bytes_q[idx_q];
	assign code.last_byte = at_last;

`ifndef SYNTHESIS
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q <= last_q)
		else $error("byte index past last byte");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !code.ready |=> busy_q && $stable(idx_q))
		else $error("byte index moved during stall");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && code.ready && at_last && !in_valid |=> !busy_q)
		else $error("serializer still busy after last byte");

	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy_q && idx_q == 3'd0)
		else $error("new instruction does not start at byte zero");
`endif

endmodule

/* src/x86_32_instruction_encoder.sv */
// x86-32 instruction encoder.
//
// Channel req (sink): one instruction request per handshake, with opcode,
// reg_a, reg_b, reg_out and a signed 32-bit immediate or displacement.
// Channel code (source): the machine code of each request, one byte per
// handshake in memory order, last_byte high on the final byte.
// Requests with an unused opcode (18..31) produce no bytes and vanish.
//
// Pipeline: input register, decode stage, byte assembly stage, then a
// byte serializer. A request's first byte is offered once it has passed these
// stages into the serializer. Throughput is set by the serializer's single
// output port: one byte per cycle while the receiver is ready. A request
// has 1 to 7 bytes, and the next request's bytes follow with no gap. Up to
// three requests wait in the stages behind the serializer.
//
// Reset clears all valid bits; no bytes are offered afterward until a
// request arrives. When the receiver stalls, the current byte holds and the
// stages fill up behind it, then req.ready drops; nothing is lost or repeated.
module x86_32_instruction_encoder
	import x86enc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	x86enc_req_if.sink    req,
	x86enc_byte_if.source code
);

	typedef enum logic [2:0] {
		K_RET,
		K_LDI,
		K_MEM,
		K_RR,
		K_MUL,
		K_IMM,
		K_UNARY,
		K_MOV
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  alu;
		logic        store;
		logic        neg;
		logic        fits;
		logic        zero;
		logic [2:0]  ra;
		logic [2:0]  rb;
		logic [2:0]  ro;
		logic [31:0] imm;
	} dec_t;

	function automatic byte_t rr_code(input logic [2:0] k);
		case (k)
			3'd0:    rr_code = 8'h01;
			3'd1:    rr_code = 8'h29;
			3'd2:    rr_code = 8'h21;
			3'd3:    rr_code = 8'h09;
			3'd4:    rr_code = 8'h31;
			default: rr_code = 8'h00;
		endcase
	endfunction

	function automatic byte_t imm_ext_code(input logic [2:0] k);
		case (k)
			3'd0:    imm_ext_code = 8'hc0;
			3'd1:    imm_ext_code = 8'he8;
			3'd2:    imm_ext_code = 8'he0;
			3'd3:    imm_ext_code = 8'hc8;
			3'd4:    imm_ext_code = 8'hf0;
			default: imm_ext_code = 8'h00;
		endcase
	endfunction

	function automatic byte_t imm_eax_code(input logic [2:0] k);
		case (k)
			3'd0:    imm_eax_code = 8'h05;
			3'd1:    imm_eax_code = 8'h2d;
			3'd2:    imm_eax_code = 8'h25;
			3'd3:    imm_eax_code = 8'h0d;
			3'd4:    imm_eax_code = 8'h35;
			default: imm_eax_code = 8'h00;
		endcase
	endfunction

	// ---------------- stage 1: request register ----------------
	logic        valid_s1;
	logic [4:0]  op_s1;
	logic [2:0]  ra_s1, rb_s1, ro_s1;
	logic [31:0] imm_s1;

	// ---------------- stage 2: decoded request ----------------
	logic        valid_s2;
	dec_t        dec_s2;
	dec_t        dec_nxt;
	logic        known_op;

	// ---------------- stage 3: assembled bytes ----------------
	logic        valid_s3;
	code_t       code_s3;
	code_t       code_nxt;

	logic        ser_ready;
	logic        rdy1, rdy2, rdy3;

	// Advance a stage when it is empty or its content moves on
	assign rdy3      = !valid_s3 || ser_ready;
	assign rdy2      = !valid_s2 || rdy3;
	assign rdy1      = !valid_s1 || rdy2;
	assign req.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= req.valid;
			end
			// Drop requests with an unused opcode here
			if (rdy2) begin
				valid_s2 <= valid_s1 && known_op;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && req.valid) begin
			op_s1  <= req.opcode;
			ra_s1  <= req.reg_a;
			rb_s1  <= req.reg_b;
			ro_s1  <= req.reg_out;
			imm_s1 <= req.immediate;
		end
		if (rdy2 && valid_s1) begin
			dec_s2 <= dec_nxt;
		end
		if (rdy3 && valid_s2) begin
			code_s3 <= code_nxt;
		end
	end

	// Decode: classify the operation and range-test the immediate
	always_comb begin
		known_op      = 1'b1;
		dec_nxt       = '0;
		dec_nxt.kind  = K_RET;
		dec_nxt.ra    = ra_s1;
		dec_nxt.rb    = rb_s1;
		dec_nxt.ro    = ro_s1;
		dec_nxt.imm   = imm_s1;
		dec_nxt.store = (op_s1 == OP_STORE);
		dec_nxt.neg   = (op_s1 == OP_NEG);
		// Signed -128..127: bits 31..7 all equal
		dec_nxt.fits  = (&imm_s1[31:7]) || !(|imm_s1[31:7]);
		dec_nxt.zero  = (imm_s1 == 32'd0);
		case (op_s1) inside
			OP_RET:               dec_nxt.kind = K_RET;
			OP_LDI:               dec_nxt.kind = K_LDI;
			OP_LOAD, OP_STORE:    dec_nxt.kind = K_MEM;
			[OP_ADD:OP_XOR]: begin
				dec_nxt.kind = K_RR;
				dec_nxt.alu  = 3'(op_s1 - OP_ADD);
			end
			OP_MUL:               dec_nxt.kind = K_MUL;
			[OP_ADD_IMM:OP_XOR_IMM]: begin
				dec_nxt.kind = K_IMM;
				dec_nxt.alu  = 3'(op_s1 - OP_ADD_IMM);
			end
			OP_NEG, OP_NOT:       dec_nxt.kind = K_UNARY;
			OP_MOVE:              dec_nxt.kind = K_MOV;
			default:              known_op = 1'b0;
		endcase
	end

	// Assemble the byte image of the decoded request
	logic       with_disp;
	logic [2:0] dpos;
	logic [1:0] mod_bits;
	logic [2:0] mem_reg;

	always_comb begin
		code_nxt  = '0;
		with_disp = !dec_s2.zero || (dec_s2.ra == 3'd5);
		dpos      = (dec_s2.ra == 3'd4) ? 3'd3 : 3'd2;
		mod_bits  = !with_disp ? 2'b00 : (dec_s2.fits ? 2'b01 : 2'b10);
		mem_reg   = dec_s2.store ? dec_s2.rb : dec_s2.ro;
		case (dec_s2.kind)
			K_RET: begin
				code_nxt.bytes[0] = 8'hc3;
				code_nxt.last_idx = 3'd0;
			end
			K_LDI: begin
				code_nxt.bytes[0] = 8'hb8 | {5'd0, dec_s2.ro};
				for (int i = 0; i < 4; i++) begin
					code_nxt.bytes[i+1] = dec_s2.imm[8*i +: 8];
				end
				code_nxt.last_idx = 3'd4;
			end
			K_MEM: begin
				code_nxt.bytes[0] = dec_s2.store ? 8'h89 : 8'h8b;
				code_nxt.bytes[1] = {mod_bits, mem_reg, dec_s2.ra};
				// esp base needs the SIB byte
				if (dec_s2.ra == 3'd4) begin
					code_nxt.bytes[2] = 8'h24;
				end
				if (!with_disp) begin
					code_nxt.last_idx = dpos - 3'd1;
				end else if (dec_s2.fits) begin
					code_nxt.bytes[dpos] = dec_s2.imm[7:0];
					code_nxt.last_idx    = dpos;
				end else begin
					for (int i = 0; i < 4; i++) begin
						code_nxt.bytes[dpos + 3'(i)] = dec_s2.imm[8*i +: 8];
					end
					code_nxt.last_idx = dpos + 3'd3;
				end
			end
			K_RR: begin
				code_nxt.bytes[0] = rr_code(dec_s2.alu);
				code_nxt.bytes[1] = {2'b11, dec_s2.rb, dec_s2.ra};
				code_nxt.last_idx = 3'd1;
			end
			K_MUL: begin
				code_nxt.bytes[0] = 8'h0f;
				code_nxt.bytes[1] = 8'haf;
				code_nxt.bytes[2] = {2'b11, dec_s2.ra, dec_s2.rb};
				code_nxt.last_idx = 3'd2;
			end
			K_IMM: begin
				if (dec_s2.ra == 3'd0) begin
					// eax short form always carries imm32
					code_nxt.bytes[0] = imm_eax_code(dec_s2.alu);
					for (int i = 0; i < 4; i++) begin
						code_nxt.bytes[i+1] = dec_s2.imm[8*i +: 8];
					end
					code_nxt.last_idx = 3'd4;
				end else begin
					code_nxt.bytes[0] = dec_s2.fits ? 8'h83 : 8'h81;
					code_nxt.bytes[1] = imm_ext_code(dec_s2.alu) | {5'd0, dec_s2.ra};
					if (dec_s2.fits) begin
						code_nxt.bytes[2] = dec_s2.imm[7:0];
						code_nxt.last_idx = 3'd2;
					end else begin
						for (int i = 0; i < 4; i++) begin
							code_nxt.bytes[i+2] = dec_s2.imm[8*i +: 8];
						end
						code_nxt.last_idx = 3'd5;
					end
				end
			end
			K_UNARY: begin
				code_nxt.bytes[0] = 8'hf7;
				code_nxt.bytes[1] = (dec_s2.neg ? 8'hd8 : 8'hd0) | {5'd0, dec_s2.ra};
				code_nxt.last_idx = 3'd1;
			end
			K_MOV: begin
				code_nxt.bytes[0] = 8'h89;
				code_nxt.bytes[1] = {2'b11, dec_s2.ra, dec_s2.ro};
				code_nxt.last_idx = 3'd1;
			end
			default: begin
				code_nxt.last_idx = 3'd0;
			end
		endcase
	end

	// Hand assembled instructions to the serializer, one byte per cycle out while the receiver is ready
	x86enc_ser u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s3),
		.in_ready (ser_ready),
		.in_code  (code_s3),
		.code     (code)
	);

endmodule
